FILE: hdl/tcc_pkg.sv
package tcc_pkg;

  localparam int CoordW     = 16;
  localparam int SqW        = 2 * CoordW + 1;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = SqW + DiffW;
  localparam int DetProdW   = CoordW + DiffW;
  localparam int NumW       = ProdW + 2;
  localparam int DetW       = DetProdW + 2;
  localparam int DenW       = DetW + 1;
  localparam int ResW       = 32;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] cx_in;
    logic signed [CoordW-1:0] cy_in;
  } in_t;

  typedef struct packed {
    logic signed [ResW-1:0] center_x;
    logic signed [ResW-1:0] center_y;
    logic                   degenerate;
    logic                   saturated;
  } out_t;

  typedef struct packed {
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic signed [DetW-1:0] det;
    logic                   degenerate;
  } work_t;

endpackage

FILE: hdl/tcc_front.sv
module tcc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcc_pkg::in_t     in_data_i,
  output logic             push_o,
  output tcc_pkg::work_t   push_data_o,
  input  logic             full_i
);

  logic en;
  logic v0_q, v1_q, v2_q, v3_q;
  tcc_pkg::in_t c0_q;

  logic signed [tcc_pkg::SqW-1:0]   s0_d, s1_d, s2_d, s0_q, s1_q, s2_q;
  logic signed [tcc_pkg::DiffW-1:0] dy12_d, dy20_d, dy01_d, dx21_d, dx02_d, dx10_d;
  logic signed [tcc_pkg::DiffW-1:0] dy12_q, dy20_q, dy01_q, dx21_q, dx02_q, dx10_q;
  logic signed [tcc_pkg::CoordW-1:0] x0_q, x1_q, x2_q;

  logic signed [tcc_pkg::ProdW-1:0] pxa_d, pxb_d, pxc_d, pya_d, pyb_d, pyc_d;
  logic signed [tcc_pkg::ProdW-1:0] pxa_q, pxb_q, pxc_q, pya_q, pyb_q, pyc_q;
  logic signed [tcc_pkg::DetProdW-1:0] pda_d, pdb_d, pdc_d, pda_q, pdb_q, pdc_q;

  tcc_pkg::work_t work_d, work_q;

  assign en         = !(v3_q && full_i);
  assign in_stall_o = !en;
  assign push_o     = v3_q && !full_i;
  assign push_data_o = work_q;

  assign s0_d   = c0_q.ax * c0_q.ax + c0_q.ay * c0_q.ay;
  assign s1_d   = c0_q.bx * c0_q.bx + c0_q.by_coord * c0_q.by_coord;
  assign s2_d   = c0_q.cx_in * c0_q.cx_in + c0_q.cy_in * c0_q.cy_in;
  assign dy12_d = c0_q.by_coord - c0_q.cy_in;
  assign dy20_d = c0_q.cy_in - c0_q.ay;
  assign dy01_d = c0_q.ay - c0_q.by_coord;
  assign dx21_d = c0_q.cx_in - c0_q.bx;
  assign dx02_d = c0_q.ax - c0_q.cx_in;
  assign dx10_d = c0_q.bx - c0_q.ax;

  assign pxa_d = s0_q * dy12_q;
  assign pxb_d = s1_q * dy20_q;
  assign pxc_d = s2_q * dy01_q;
  assign pya_d = s0_q * dx21_q;
  assign pyb_d = s1_q * dx02_q;
  assign pyc_d = s2_q * dx10_q;
  assign pda_d = x0_q * dy12_q;
  assign pdb_d = x1_q * dy20_q;
  assign pdc_d = x2_q * dy01_q;

  always_comb begin
    work_d.nx         = pxa_q + pxb_q + pxc_q;
    work_d.ny         = pya_q + pyb_q + pyc_q;
    work_d.det        = pda_q + pdb_q + pdc_q;
    work_d.degenerate = (work_d.det == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q   <= in_data_i;
      s0_q   <= s0_d;
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      dy12_q <= dy12_d;
      dy20_q <= dy20_d;
      dy01_q <= dy01_d;
      dx21_q <= dx21_d;
      dx02_q <= dx02_d;
      dx10_q <= dx10_d;
      x0_q   <= c0_q.ax;
      x1_q   <= c0_q.bx;
      x2_q   <= c0_q.cx_in;
      pxa_q  <= pxa_d;
      pxb_q  <= pxb_d;
      pxc_q  <= pxc_d;
      pya_q  <= pya_d;
      pyb_q  <= pyb_d;
      pyc_q  <= pyc_d;
      pda_q  <= pda_d;
      pdb_q  <= pdb_d;
      pdc_q  <= pdc_d;
      work_q <= work_d;
    end
  end

endmodule

FILE: hdl/tcc_queue.sv
module tcc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcc_pkg::work_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tcc_pkg::work_t pop_data_o
);

  tcc_pkg::work_t mem_q [tcc_pkg::QueueDepth];
  logic [tcc_pkg::QueueAw-1:0] wr_q, rd_q;
  logic [tcc_pkg::QueueAw:0]   cnt_q;

  assign full_o     = (cnt_q == (tcc_pkg::QueueAw+1)'(tcc_pkg::QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/tcc_back.sv
module tcc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  output logic           pop_o,
  input  tcc_pkg::work_t pop_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tcc_pkg::out_t  out_data_o
);

  localparam int NumW = tcc_pkg::NumW;
  localparam int DenW = tcc_pkg::DenW;
  localparam int ResW = tcc_pkg::ResW;
  localparam int DetW_LOCAL = tcc_pkg::DetW;
  localparam logic [NumW-1:0] PosMax = NumW'(33'h0_7FFF_FFFF);
  localparam logic [NumW-1:0] NegMax = NumW'(33'h0_8000_0000);

  logic en;
  logic          v_q   [NumW+1];
  logic [DenW-1:0] d_q [NumW+1];
  logic [DenW-1:0] rx_q [NumW+1];
  logic [DenW-1:0] ry_q [NumW+1];
  logic [NumW-1:0] nx_q [NumW+1];
  logic [NumW-1:0] ny_q [NumW+1];
  logic          sx_q  [NumW+1];
  logic          sy_q  [NumW+1];
  logic          dg_q  [NumW+1];

  logic [NumW-1:0] magx, magy;
  logic [DetW_LOCAL-1:0] dmag;

  logic          vout_q;
  tcc_pkg::out_t out_d, out_q;

  assign en          = !(vout_q && out_stall_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vout_q;
  assign out_data_o  = out_q;

  assign magx = pop_data_i.nx[NumW-1] ? NumW'(-pop_data_i.nx) : NumW'(pop_data_i.nx);
  assign magy = pop_data_i.ny[NumW-1] ? NumW'(-pop_data_i.ny) : NumW'(pop_data_i.ny);
  assign dmag = pop_data_i.det[DetW_LOCAL-1] ? DetW_LOCAL'(-pop_data_i.det)
                                             : DetW_LOCAL'(pop_data_i.det);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0]  <= {dmag, 1'b0};
      rx_q[0] <= '0;
      ry_q[0] <= '0;
      nx_q[0] <= magx;
      ny_q[0] <= magy;
      sx_q[0] <= pop_data_i.nx[NumW-1] ^ pop_data_i.det[DetW_LOCAL-1];
      sy_q[0] <= pop_data_i.ny[NumW-1] ^ pop_data_i.det[DetW_LOCAL-1];
      dg_q[0] <= pop_data_i.degenerate;
    end
  end

  for (genvar i = 0; i < NumW; i++) begin : g_div
    logic [DenW:0]   tx, ty, dd;
    logic            gex, gey;
    logic [DenW-1:0] rxn, ryn;

    assign dd  = {1'b0, d_q[i]};
    assign tx  = {rx_q[i], nx_q[i][NumW-1]};
    assign ty  = {ry_q[i], ny_q[i][NumW-1]};
    assign gex = (tx >= dd);
    assign gey = (ty >= dd);
    assign rxn = gex ? DenW'(tx - dd) : DenW'(tx);
    assign ryn = gey ? DenW'(ty - dd) : DenW'(ty);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q[i+1]  <= d_q[i];
        rx_q[i+1] <= rxn;
        ry_q[i+1] <= ryn;
        nx_q[i+1] <= {nx_q[i][NumW-2:0], gex};
        ny_q[i+1] <= {ny_q[i][NumW-2:0], gey};
        sx_q[i+1] <= sx_q[i];
        sy_q[i+1] <= sy_q[i];
        dg_q[i+1] <= dg_q[i];
      end
    end
  end

  always_comb begin
    logic satx, saty;
    logic [NumW-1:0] qx, qy;
    qx   = nx_q[NumW];
    qy   = ny_q[NumW];
    satx = sx_q[NumW] ? (qx > NegMax) : (qx > PosMax);
    saty = sy_q[NumW] ? (qy > NegMax) : (qy > PosMax);
    if (satx) begin
      out_d.center_x = sx_q[NumW] ? ResW'(NegMax) : ResW'(PosMax);
    end else begin
      out_d.center_x = sx_q[NumW] ? ResW'(-qx) : ResW'(qx);
    end
    if (saty) begin
      out_d.center_y = sy_q[NumW] ? ResW'(NegMax) : ResW'(PosMax);
    end else begin
      out_d.center_y = sy_q[NumW] ? ResW'(-qy) : ResW'(qy);
    end
    out_d.saturated  = satx || saty;
    out_d.degenerate = dg_q[NumW];
    if (dg_q[NumW]) begin
      out_d.center_x  = '0;
      out_d.center_y  = '0;
      out_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= v_q[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: hdl/triangle_circumcenter.sv
// Circumcenter of a 2D triangle. Each item carries three Q3.12 vertices and
// gives one Q19.12 center, truncated toward zero, clamped to 32 bits with
// the saturated flag, or zero with the degenerate flag for collinear
// vertices. One item is accepted per cycle while in_stall_o is low. The
// pipeline has four front stages that form the squares, products and the
// determinant, one queue stage, and the back end spends one setup stage,
// 52 restoring division stages (one quotient bit each, x and y in parallel)
// and an output register. The four-entry queue between front and back lets
// each side stall independently.
module triangle_circumcenter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcc_pkg::out_t out_data_o
);

  logic           push, full, pop, empty;
  tcc_pkg::work_t push_data, pop_data;

  tcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: verif/triangle_circumcenter_tb.sv
module triangle_circumcenter_tb;

  localparam int LatencyCycles = 80;
  localparam int CycleLimit    = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tcc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tcc_pkg::out_t out_data_o;

  tcc_pkg::out_t centre_queue[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit long_hold = 1'b0;
  bit stall_enable = 1'b1;

  triangle_circumcenter u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp_centre(longint q, ref bit sat);
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic tcc_pkg::out_t circumcentre(tcc_pkg::in_t t);
    longint x0, y0, x1, y1, x2, y2, s0, s1, s2, det, nx, ny;
    bit sat;
    tcc_pkg::out_t r;
    x0 = t.ax; y0 = t.ay; x1 = t.bx; y1 = t.by_coord; x2 = t.cx_in; y2 = t.cy_in;
    s0 = x0 * x0 + y0 * y0;
    s1 = x1 * x1 + y1 * y1;
    s2 = x2 * x2 + y2 * y2;
    det = x0 * (y1 - y2) + x1 * (y2 - y0) + x2 * (y0 - y1);
    nx = s0 * (y1 - y2) + s1 * (y2 - y0) + s2 * (y0 - y1);
    ny = s0 * (x2 - x1) + s1 * (x0 - x2) + s2 * (x1 - x0);
    r = '0;
    sat = 1'b0;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.center_x = clamp_centre(nx / (2 * det), sat);
    r.center_y = clamp_centre(ny / (2 * det), sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic send_triangle(tcc_pkg::in_t t);
    in_valid_i <= 1'b1;
    in_data_i <= t;
    centre_queue = {centre_queue, circumcentre(t)};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (centre_queue.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord(int unsigned mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 15)) - 16'sd8;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed(16'($urandom_range(0, 1023))) - 16'sd512);
    endcase
  endfunction

  function automatic tcc_pkg::in_t random_triangle();
    tcc_pkg::in_t t;
    int unsigned mode;
    int signed k;
    mode = $urandom_range(0, 9);
    t.ax = rand_coord(mode % 4);
    t.ay = rand_coord(mode % 4);
    t.bx = rand_coord($urandom_range(0, 3));
    t.by_coord = rand_coord($urandom_range(0, 3));
    t.cx_in = rand_coord(mode % 4);
    t.cy_in = rand_coord(mode % 4);
    if (mode == 9) begin
      // Collinear or near-collinear: third vertex on the line through the first two.
      k = $urandom_range(0, 3) - 1;
      t.cx_in = 16'(t.ax + k * (t.bx - t.ax));
      t.cy_in = 16'(t.ay + k * (t.by_coord - t.ay) + $urandom_range(0, 1));
    end
    return t;
  endfunction

  task automatic test_directed();
    send_triangle('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_triangle('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000});
    send_triangle('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_triangle('{16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd3, 16'sd3});
    send_triangle('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    send_triangle('{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096});
    send_triangle('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
    send_triangle('{16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd1});
    send_triangle('{16'sd0, 16'sh8000, 16'sd0, 16'sh7fff, 16'sd1, 16'sd0});
    send_triangle('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe});
    send_triangle('{-16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, -16'sd4096});
    send_triangle('{16'shffff, 16'shffff, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555});
    send_triangle('{16'sd3, -16'sd7, -16'sd5, 16'sd2, 16'sd1, 16'sd9});
    send_triangle('{16'sh7fff, 16'sd0, 16'sh8000, 16'sd0, 16'sd5, 16'sd0});
    send_triangle('{16'sh1234, 16'sh4321, 16'sh1234, 16'sh4321, -16'sd3, 16'sd11});
    drain_results();
  endtask

  task automatic test_random_bursts(int unsigned n);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_triangle(random_triangle());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    drain_results();
  endtask

  task automatic test_back_pressure();
    long_hold = 1'b1;
    repeat (120) send_triangle(random_triangle());
    long_hold = 1'b0;
    drain_results();
  endtask

  task automatic test_no_gaps(int unsigned n);
    stall_enable = 1'b0;
    repeat (n) send_triangle(random_triangle());
    drain_results();
    stall_enable = 1'b1;
  endtask

  // Receiver stall pattern: runs of stall and go of random length, or a long
  // hold-off while the sender keeps offering items.
  initial begin
    int unsigned run;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i <= 1'b0;
        while (long_hold) @(negedge clk_i);
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        run = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (run - 1) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        run = $urandom_range(1, 20);
        out_stall_i <= 1'b0;
        repeat (run - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    tcc_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (centre_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data_o);
        error_count++;
      end else begin
        want = centre_queue.pop_front();
        if (out_data_o.center_x !== want.center_x) begin
          $display("%0t: center_x expected %0d actual %0d", $realtime,
                   want.center_x, out_data_o.center_x);
          error_count++;
        end
        if (out_data_o.center_y !== want.center_y) begin
          $display("%0t: center_y expected %0d actual %0d", $realtime,
                   want.center_y, out_data_o.center_y);
          error_count++;
        end
        if (out_data_o.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $realtime,
                   want.degenerate, out_data_o.degenerate);
          error_count++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $realtime,
                   want.saturated, out_data_o.saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_bursts(500);
    test_back_pressure();
    test_no_gaps(150);
    test_random_bursts(340);
    repeat (LatencyCycles) @(negedge clk_i);
    if (error_count == 0 && centre_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tcc_pkg.sv
hdl/tcc_front.sv
hdl/tcc_queue.sv
hdl/tcc_back.sv
hdl/triangle_circumcenter.sv
verif/triangle_circumcenter_tb.sv
